// ===== hw/rtl/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types and codes shared by the i2c master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // item kinds on the request channel
  typedef enum logic [0:0] {
    OP_ENQUEUE = 1'b0,
    OP_EVENT   = 1'b1
  } op_e;

  // bus commands
  typedef enum logic [2:0] {
    CMD_SEND      = 3'd0,
    CMD_RECV_ACK  = 3'd2,
    CMD_RECV_NACK = 3'd3,
    CMD_START     = 3'd4,
    CMD_RESTART   = 3'd5,
    CMD_STOP      = 3'd6
  } cmd_e;

  // request payload: descriptor or status event
  typedef struct packed {
    op_e         opcode;
    logic [6:0]  target_address;
    logic [15:0] write_length;
    logic [15:0] write_length_second;
    logic [15:0] read_length;
    logic        ack_flag;
    logic        receive_flag;
    logic        start_seen_flag;
    logic [7:0]  write_byte;
    logic [7:0]  received_byte;
  } req_t;

  // result payload
  typedef struct packed {
    logic        request_accepted;
    logic        command_valid;
    cmd_e        command_code;
    logic [7:0]  command_data;
    logic        write_byte_used;
    logic        write_segment;
    logic        read_valid;
    logic [7:0]  read_data;
    logic        transaction_done;
    logic        busy_res;
  } res_t;

  // queued transfer descriptor
  typedef struct packed {
    logic [15:0] read_length;
    logic [15:0] write_length_second;
    logic [15:0] write_length;
    logic [6:0]  target_address;
  } desc_t;

  // queue control from the sequencer core
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  // queue status to the sequencer core
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hw/rtl/i2cms_req_if.sv =====
// ----------------------------------------------------------------------------
// i2cms_req_if
// Request channel: descriptors and bus status events with valid/ready.
// ----------------------------------------------------------------------------
interface i2cms_req_if
  import i2cms_pkg::*;
();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/i2cms_res_if.sv =====
// ----------------------------------------------------------------------------
// i2cms_res_if
// Result channel: one result per request with valid/ready.
// ----------------------------------------------------------------------------
interface i2cms_res_if
  import i2cms_pkg::*;
();
  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/i2c_master_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// I2C master write/write/read transaction sequencer with descriptor queue.
// ----------------------------------------------------------------------------
// Every request transaction (a descriptor or a bus status event) yields
// exactly one result transaction, so a new request can be taken every cycle
// while the output stages have room. Request ready drops only when both
// output stages hold results the sink has not taken. Pending descriptors sit
// in a QUEUE_DEPTH entry synchronous memory; its head entry is read ahead
// into a register, with write forwarding, so a completion starts the next
// descriptor in the same cycle. No clearing pass follows reset.
module i2c_master_transfer_sequencer
  import i2cms_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  i2cms_req_if.sink   req_i,
  i2cms_res_if.source res_o
);

  logic    fire;
  logic    buf_ready;
  q_ctrl_t q_ctrl;
  q_stat_t q_stat;
  desc_t   q_head;
  desc_t   q_push_data;
  res_t    core_res;

  assign req_i.ready = buf_ready;
  assign fire        = req_i.valid && buf_ready;

  // descriptor fifo
  i2cms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (q_ctrl),
    .push_data_i (q_push_data),
    .stat_o      (q_stat),
    .head_data_o (q_head)
  );

  // transfer state and command decision
  i2cms_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .req_i         (req_i.payload),
    .q_stat_i      (q_stat),
    .q_head_i      (q_head),
    .q_ctrl_o      (q_ctrl),
    .q_push_data_o (q_push_data),
    .res_o         (core_res)
  );

  // result register with skid stage
  i2cms_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .data_i  (core_res),
    .ready_o (buf_ready),
    .res_o   (res_o)
  );

endmodule

// ===== hw/rtl/i2cms_queue.sv =====
// ----------------------------------------------------------------------------
// i2cms_queue
// Pending descriptor fifo in a synchronous memory. The head entry is read
// ahead every cycle so it is ready when the active transfer completes.
// ----------------------------------------------------------------------------
module i2cms_queue
  import i2cms_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_ctrl_t ctrl_i,
  input  desc_t   push_data_i,
  output q_stat_t stat_o,
  output desc_t   head_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  desc_t          mem [DEPTH];
  desc_t          head_data_q;
  logic [AW-1:0]  head_q, head_d;
  logic [CW-1:0]  count_q, count_d;
  logic [SW-1:0]  tail_sum;
  logic [AW-1:0]  wr_addr;

  // tail slot: head plus fill count, wrapped once
  always_comb begin
    tail_sum = SW'(head_q) + SW'(count_q);
    if (tail_sum >= SW'(DEPTH)) begin
      tail_sum = tail_sum - SW'(DEPTH);
    end
    wr_addr = tail_sum[AW-1:0];
  end

  // pointer and fill count update
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctrl_i.pop) begin
      head_d  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
      count_d = count_d - CW'(1);
    end
    if (ctrl_i.push) begin
      count_d = count_d + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // memory write port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[wr_addr] <= push_data_i;
    end
  end

  // memory read port at the next head, write data forwarded on a match
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && (wr_addr == head_d)) begin
      head_data_q <= push_data_i;
    end else begin
      head_data_q <= mem[head_d];
    end
  end

  assign head_data_o  = head_data_q;
  assign stat_o.full  = (count_q == CW'(DEPTH));
  assign stat_o.empty = (count_q == '0);

endmodule

// ===== hw/rtl/i2cms_core.sv =====
// ----------------------------------------------------------------------------
// i2cms_core
// Active transfer state and the command decision for each request.
// ----------------------------------------------------------------------------
module i2cms_core
  import i2cms_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  req_t    req_i,
  input  q_stat_t q_stat_i,
  input  desc_t   q_head_i,
  output q_ctrl_t q_ctrl_o,
  output desc_t   q_push_data_o,
  output res_t    res_o
);

  logic        active_q, active_d;
  logic [6:0]  addr_q, addr_d;
  logic [15:0] wr_rem_q, wr_rem_d;
  logic [15:0] wr2_rem_q, wr2_rem_d;
  logic        on_second_q, on_second_d;
  logic [15:0] rd_rem_q, rd_rem_d;
  logic        load;
  desc_t       load_desc;
  desc_t       req_desc;

  assign req_desc.target_address      = req_i.target_address;
  assign req_desc.write_length        = req_i.write_length;
  assign req_desc.write_length_second = req_i.write_length_second;
  assign req_desc.read_length         = req_i.read_length;
  assign q_push_data_o                = req_desc;

  // command decision and next state
  always_comb begin
    active_d    = active_q;
    addr_d      = addr_q;
    wr_rem_d    = wr_rem_q;
    wr2_rem_d   = wr2_rem_q;
    on_second_d = on_second_q;
    rd_rem_d    = rd_rem_q;
    load        = 1'b0;
    load_desc   = req_desc;
    q_ctrl_o    = '0;
    res_o       = '0;
    res_o.command_code = CMD_SEND;

    if (fire_i) begin
      unique case (req_i.opcode)
        OP_ENQUEUE: begin
          if ((req_i.write_length != '0) || (req_i.read_length != '0)) begin
            if (!active_q) begin
              res_o.request_accepted = 1'b1;
              load = 1'b1;
            end else if (!q_stat_i.full) begin
              res_o.request_accepted = 1'b1;
              q_ctrl_o.push = 1'b1;
            end
          end
        end
        OP_EVENT: begin
          if (active_q) begin
            if (req_i.ack_flag) begin
              res_o.command_valid = 1'b1;
              if (wr_rem_q != '0) begin
                // next write byte
                res_o.command_code    = CMD_SEND;
                res_o.command_data    = req_i.write_byte;
                res_o.write_byte_used = 1'b1;
                res_o.write_segment   = on_second_q;
                wr_rem_d = wr_rem_q - 16'd1;
                if ((wr_rem_q == 16'd1) && (wr2_rem_q != '0)) begin
                  wr_rem_d    = wr2_rem_q;
                  wr2_rem_d   = '0;
                  on_second_d = 1'b1;
                end
              end else if (rd_rem_q != '0) begin
                if (req_i.start_seen_flag) begin
                  res_o.command_code = CMD_RECV_ACK;
                end else begin
                  res_o.command_code = CMD_RESTART;
                  res_o.command_data = {addr_q, 1'b1};
                end
              end else begin
                res_o.command_code = CMD_STOP;
              end
            end else if (req_i.receive_flag) begin
              res_o.command_valid = 1'b1;
              if (rd_rem_q != '0) begin
                res_o.read_valid = 1'b1;
                res_o.read_data  = req_i.received_byte;
                rd_rem_d = rd_rem_q - 16'd1;
              end
              res_o.command_code = (rd_rem_q > 16'd1) ? CMD_RECV_ACK : CMD_RECV_NACK;
            end else begin
              // completion: start the next queued transfer or go idle
              res_o.transaction_done = 1'b1;
              if (!q_stat_i.empty) begin
                q_ctrl_o.pop = 1'b1;
                load      = 1'b1;
                load_desc = q_head_i;
              end else begin
                active_d    = 1'b0;
                wr_rem_d    = '0;
                wr2_rem_d   = '0;
                rd_rem_d    = '0;
                on_second_d = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end

    // load a descriptor and issue its start
    if (load) begin
      active_d    = 1'b1;
      addr_d      = load_desc.target_address;
      wr_rem_d    = load_desc.write_length;
      wr2_rem_d   = load_desc.write_length_second;
      on_second_d = 1'b0;
      rd_rem_d    = load_desc.read_length;
      res_o.command_valid = 1'b1;
      res_o.command_code  = CMD_START;
      res_o.command_data  = {load_desc.target_address, (load_desc.write_length == '0)};
    end

    res_o.busy_res = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      addr_q      <= '0;
      wr_rem_q    <= '0;
      wr2_rem_q   <= '0;
      on_second_q <= 1'b0;
      rd_rem_q    <= '0;
    end else begin
      active_q    <= active_d;
      addr_q      <= addr_d;
      wr_rem_q    <= wr_rem_d;
      wr2_rem_q   <= wr2_rem_d;
      on_second_q <= on_second_d;
      rd_rem_q    <= rd_rem_d;
    end
  end

endmodule

// ===== hw/rtl/i2cms_out_buf.sv =====
// ----------------------------------------------------------------------------
// i2cms_out_buf
// Two-entry output register with skid stage; ready depends only on state.
// ----------------------------------------------------------------------------
module i2cms_out_buf
  import i2cms_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  res_t  data_i,
  output logic  ready_o,
  i2cms_res_if.source res_o
);

  logic main_valid_q, main_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t main_q, main_d;
  res_t skid_q, skid_d;
  logic pop;

  assign pop     = main_valid_q && res_o.ready;
  assign ready_o = !skid_valid_q;

  // stage movement
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        main_d = data_i;
      end else begin
        main_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q) begin
        main_d       = data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign res_o.valid   = main_valid_q;
  assign res_o.payload = main_q;

endmodule
